### design/mfhd_pkg.sv
package mfhd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned RoleW   = 2;
  localparam int unsigned OffsetW = 24;
  localparam int unsigned TypeW   = 4;
  localparam int unsigned LenW    = 28;
  localparam int unsigned CapW    = 24;

  localparam logic [CapW-1:0] CapReset = 24'd20480;
  localparam int unsigned MaxLenBytesDefault = 4;

  localparam logic [RoleW-1:0] RoleCommand = 2'd0;
  localparam logic [RoleW-1:0] RoleLength  = 2'd1;
  localparam logic [RoleW-1:0] RolePayload = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0]   data_byte;
    logic [RoleW-1:0]   byte_role;
    logic [OffsetW-1:0] byte_offset;
    logic [TypeW-1:0]   packet_type;
    logic [LenW-1:0]    remaining_length;
    logic               end_of_packet;
    logic               status;
  } result_t;

endpackage

### design/mfhd_core.sv
module mfhd_core #(
  parameter int unsigned MaxLenBytes = mfhd_pkg::MaxLenBytesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [mfhd_pkg::ByteW-1:0]   rx_byte_i,
  input  logic                         cfg_we_i,
  input  logic [mfhd_pkg::CapW-1:0]    cfg_wdata_i,
  output mfhd_pkg::result_t            result_o
);
  import mfhd_pkg::*;

  localparam logic [1:0] PhCommand = 2'd0;
  localparam logic [1:0] PhLength  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

  logic [1:0]         phase_q, phase_d;
  logic [ByteW-1:0]   cmd_q, cmd_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [LenW-1:0]    left_q, left_d;
  logic [OffsetW-1:0] pos_q, pos_d;
  logic               over_q, over_d;
  logic [CapW-1:0]    cap_q;

  logic [LenW-1:0]    group;
  logic [LenW-1:0]    len_acc;
  logic [2:0]         cnt_inc;
  logic [LenW:0]      total;
  logic               len_done;
  logic [LenW-1:0]    left_dec;

  always_comb begin
    // 7-bit group placed by its index in the length field
    case (cnt_q[1:0])
      2'd0: group = {21'd0, rx_byte_i[6:0]};
      2'd1: group = {14'd0, rx_byte_i[6:0], 7'd0};
      2'd2: group = {7'd0, rx_byte_i[6:0], 14'd0};
      2'd3: group = {rx_byte_i[6:0], 21'd0};
      default: group = '0;
    endcase
    len_acc  = (cnt_q < 3'd4) ? (len_q | group) : len_q;
    cnt_inc  = cnt_q + 3'd1;
    len_done = (cnt_inc >= 3'(MaxLenBytes)) || !rx_byte_i[7];
    total    = {1'b0, len_acc} + {{(LenW-2){1'b0}}, cnt_inc} + {{LenW{1'b0}}, 1'b1};
    left_dec = (left_q != '0) ? (left_q - 1'b1) : left_q;
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    pos_d   = pos_q + 1'b1;
    over_d  = over_q;

    result_o.data_byte        = rx_byte_i;
    result_o.byte_offset      = pos_q;
    result_o.packet_type      = cmd_q[7:4];
    result_o.remaining_length = len_q;
    result_o.end_of_packet    = 1'b0;
    result_o.byte_role        = RolePayload;

    case (phase_q)
      PhCommand: begin
        result_o.byte_role        = RoleCommand;
        result_o.packet_type      = rx_byte_i[7:4];
        result_o.remaining_length = '0;
        cmd_d   = rx_byte_i;
        len_d   = '0;
        cnt_d   = '0;
        phase_d = PhLength;
      end
      PhLength: begin
        result_o.byte_role        = RoleLength;
        result_o.remaining_length = len_acc;
        len_d = len_acc;
        cnt_d = cnt_inc;
        if (len_done) begin
          if (total > {{(LenW+1-CapW){1'b0}}, cap_q}) begin
            over_d = 1'b1;
          end
          left_d = len_acc;
          if (len_acc == '0) begin
            result_o.end_of_packet = 1'b1;
            phase_d = PhCommand;
            cmd_d   = '0;
            len_d   = '0;
            cnt_d   = '0;
            left_d  = '0;
            pos_d   = '0;
          end else begin
            phase_d = PhPayload;
          end
        end
      end
      default: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          result_o.end_of_packet = 1'b1;
          phase_d = PhCommand;
          cmd_d   = '0;
          len_d   = '0;
          cnt_d   = '0;
          pos_d   = '0;
        end
      end
    endcase
    result_o.status = over_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhCommand;
      cmd_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      pos_q   <= '0;
      over_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      over_q  <= over_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

endmodule

### design/mfhd_out_reg.sv
module mfhd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mfhd_pkg::result_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mfhd_pkg::result_t out_data_o
);
  import mfhd_pkg::*;

  logic    valid_q;
  result_t data_q;

  // new request may land while the held one leaves in the same cycle
  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

endmodule

### design/mqtt_fixed_header_deframer_top.sv
// Channel   Handshake                  Payload
// rx        rx_valid_i / rx_ready_o    rx_byte_i
// out       out_valid_o / out_ready_i  data_byte_o .. status_o
// cfg       cfg_we_i                   cfg_wdata_i (buffer capacity)
//
// One byte per cycle while rx_ready_o is high; the result appears in the output register
// in the cycle after its request is taken. Framing state updates in the same cycle.
// Reset clears the framing state and the oversize flag, capacity to 20480.
// rx_ready_o drops only while a held result is not taken by the sink.
module mqtt_fixed_header_deframer_top #(
  parameter int unsigned MaxLenBytes = mfhd_pkg::MaxLenBytesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rx_valid_i,
  output logic                         rx_ready_o,
  input  logic [mfhd_pkg::ByteW-1:0]   rx_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mfhd_pkg::ByteW-1:0]   data_byte_o,
  output logic [mfhd_pkg::RoleW-1:0]   byte_role_o,
  output logic [mfhd_pkg::OffsetW-1:0] byte_offset_o,
  output logic [mfhd_pkg::TypeW-1:0]   packet_type_o,
  output logic [mfhd_pkg::LenW-1:0]    remaining_length_o,
  output logic                         end_of_packet_o,
  output logic                         status_o,
  input  logic                         cfg_we_i,
  input  logic [mfhd_pkg::CapW-1:0]    cfg_wdata_i
);
  import mfhd_pkg::*;

  result_t core_res;
  result_t out_res;
  logic    accept;

  assign accept = rx_valid_i && rx_ready_o;

  mfhd_core #(
    .MaxLenBytes(MaxLenBytes)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .result_o   (core_res)
  );

  mfhd_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_valid_i),
    .in_ready_o (rx_ready_o),
    .in_data_i  (core_res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_res)
  );

  assign data_byte_o        = out_res.data_byte;
  assign byte_role_o        = out_res.byte_role;
  assign byte_offset_o      = out_res.byte_offset;
  assign packet_type_o      = out_res.packet_type;
  assign remaining_length_o = out_res.remaining_length;
  assign end_of_packet_o    = out_res.end_of_packet;
  assign status_o           = out_res.status;

endmodule

### test/testbench.sv
module testbench;
  import mfhd_pkg::*;

  localparam int unsigned MaxLenBytes = MaxLenBytesDefault;
  localparam int unsigned RunLimit    = 2000000;

  typedef enum logic [1:0] {AwaitCommand, InLengthField, InPayload} frame_phase_e;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              rx_valid_i  = 1'b0;
  logic              rx_ready_o;
  logic [ByteW-1:0]  rx_byte_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ByteW-1:0]  data_byte_o;
  logic [RoleW-1:0]  byte_role_o;
  logic [OffsetW-1:0] byte_offset_o;
  logic [TypeW-1:0]  packet_type_o;
  logic [LenW-1:0]   remaining_length_o;
  logic              end_of_packet_o;
  logic              status_o;
  logic              cfg_we_i    = 1'b0;
  logic [CapW-1:0]   cfg_wdata_i = '0;

  mqtt_fixed_header_deframer_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rx_valid_i         (rx_valid_i),
    .rx_ready_o         (rx_ready_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .data_byte_o        (data_byte_o),
    .byte_role_o        (byte_role_o),
    .byte_offset_o      (byte_offset_o),
    .packet_type_o      (packet_type_o),
    .remaining_length_o (remaining_length_o),
    .end_of_packet_o    (end_of_packet_o),
    .status_o           (status_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // framing model state
  logic [CapW-1:0]    capacity_model = CapReset;
  frame_phase_e       frame_phase    = AwaitCommand;
  logic [7:0]         cmd_held       = '0;
  logic [LenW-1:0]    length_acc     = '0;
  logic [2:0]         length_bytes   = '0;
  logic [LenW-1:0]    payload_left   = '0;
  logic [OffsetW-1:0] packet_pos     = '0;
  logic               oversize_seen  = 1'b0;

  result_t     framed_q[$];
  int unsigned errors        = 0;
  int unsigned items_sent    = 0;
  int unsigned packets_seen  = 0;
  int unsigned empty_packets = 0;
  int unsigned burst_left    = 0;
  bit          gaps_on       = 1'b1;
  int unsigned sink_mode     = 1;
  int unsigned sink_hold     = 0;
  int unsigned sink_phase    = 0;

  function automatic void clear_frame();
    frame_phase  = AwaitCommand;
    cmd_held     = '0;
    length_acc   = '0;
    length_bytes = '0;
    payload_left = '0;
    packet_pos   = '0;
  endfunction

  function automatic result_t frame_byte(input logic [7:0] b);
    result_t     r;
    logic [31:0] total;
    r = '0;
    r.data_byte   = b;
    r.byte_offset = packet_pos;
    case (frame_phase)
      AwaitCommand: begin
        cmd_held      = b;
        r.byte_role   = RoleCommand;
        r.packet_type = b[7:4];
        length_acc    = '0;
        length_bytes  = '0;
        packet_pos    = packet_pos + 1'b1;
        frame_phase   = InLengthField;
      end
      InLengthField: begin
        r.byte_role   = RoleLength;
        r.packet_type = cmd_held[7:4];
        if (length_bytes < 4) begin
          length_acc = length_acc | LenW'(LenW'(b[6:0]) << (7 * length_bytes));
        end
        length_bytes       = length_bytes + 1'b1;
        packet_pos         = packet_pos + 1'b1;
        r.remaining_length = length_acc;
        if (length_bytes >= MaxLenBytes || !b[7]) begin
          // packet size counts the command byte as well
          total = 32'(length_bytes) + 32'd1 + 32'(length_acc);
          if (total > 32'(capacity_model)) oversize_seen = 1'b1;
          payload_left = length_acc;
          if (payload_left == 0) begin
            r.end_of_packet = 1'b1;
            empty_packets++;
            clear_frame();
          end else begin
            frame_phase = InPayload;
          end
        end
      end
      default: begin
        r.byte_role        = RolePayload;
        r.packet_type      = cmd_held[7:4];
        r.remaining_length = length_acc;
        packet_pos         = packet_pos + 1'b1;
        if (payload_left > 0) payload_left = payload_left - 1'b1;
        if (payload_left == 0) begin
          r.end_of_packet = 1'b1;
          clear_frame();
        end
      end
    endcase
    r.status = oversize_seen;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: exp byte=%h role=%0d off=%0d type=%h rlen=%0d eop=%b st=%b",
               $time, what, want.data_byte, want.byte_role, want.byte_offset,
               want.packet_type, want.remaining_length, want.end_of_packet, want.status);
      $display("%0t %s: got byte=%h role=%0d off=%0d type=%h rlen=%0d eop=%b st=%b",
               $time, what, got.data_byte, got.byte_role, got.byte_offset,
               got.packet_type, got.remaining_length, got.end_of_packet, got.status);
    end
  endtask

  // result checker
  result_t got_result, want_result;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_result = {data_byte_o, byte_role_o, byte_offset_o, packet_type_o,
                    remaining_length_o, end_of_packet_o, status_o};
      if (framed_q.size() == 0) begin
        report_mismatch("unexpected result", '0, got_result);
      end else begin
        want_result = framed_q.pop_front();
        if (got_result !== want_result) report_mismatch("mismatch", want_result, got_result);
        if (want_result.end_of_packet) packets_seen++;
      end
    end
  end

  // sink: long holds take priority over the stall pattern
  always @(negedge clk_i) begin
    sink_phase++;
    if (sink_hold > 0) begin
      out_ready_i = 1'b0;
      sink_hold--;
    end else begin
      case (sink_mode)
        0:       out_ready_i = 1'b1;
        1:       out_ready_i = ($urandom_range(0, 3) != 0);
        default: out_ready_i = ((sink_phase % 7) < 4);
      endcase
    end
  end

  task automatic send_rx(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        rx_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    rx_valid_i = 1'b1;
    rx_byte_i  = b;
    do @(posedge clk_i); while (!rx_ready_o);
    framed_q.push_back(frame_byte(b));
    items_sent++;
  endtask

  task automatic send_packet(input logic [7:0] cmd, input int unsigned len,
                             input int unsigned nlen, input bit last_cont);
    logic [7:0] lb;
    send_rx(cmd);
    for (int i = 0; i < nlen; i++) begin
      lb[6:0] = 7'(len >> (7 * i));
      lb[7]   = (i < nlen - 1) || (last_cont && i == 3);
      send_rx(lb);
    end
    repeat (len) send_rx(8'($urandom));
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    rx_valid_i = 1'b0;
    burst_left = 0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i       = 1'b0;
    capacity_model = value;
  endtask

  // runs at the reset capacity
  task automatic test_directed_framing();
    gaps_on   = 1'b1;
    sink_mode = 1;
    send_rx(8'h00); send_rx(8'h00);                  // zero command, empty packet
    send_rx(8'hFF); send_rx(8'h00);
    send_rx(8'h30); send_rx(8'h03);
    send_rx(8'h00); send_rx(8'hFF); send_rx(8'h55);
    send_rx(8'hC0); send_rx(8'h80); send_rx(8'h00);  // padded zero length
    // length field cut after four bytes, top bit of the last one ignored
    send_rx(8'h82); send_rx(8'h81); send_rx(8'h80); send_rx(8'h80); send_rx(8'h80);
    send_rx(8'hAA);
    send_rx(8'h6F); send_rx(8'h02); send_rx(8'hFF); send_rx(8'h00);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at, len, need, pick, nlen;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      len = $urandom_range(0, 15);
      else if (pick < 95) len = $urandom_range(16, 200);
      else                len = $urandom_range(201, 700);
      need = (len < 128) ? 1 : 2;
      nlen = $urandom_range(need, 4);
      send_packet(8'($urandom), len, nlen, (nlen == 4) && ($urandom_range(0, 1) == 1));
    end
    wait_idle();
  endtask

  // two-byte header plus four payload bytes against capacities 6 and 5
  task automatic test_oversize_boundary();
    write_capacity(24'd6);
    send_packet(8'h30, 4, 1, 1'b0);
    write_capacity(24'd5);
    send_packet(8'h30, 4, 1, 1'b0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    gaps_on   = 1'b0;
    sink_hold = 80;
    send_packet(8'h92, 30, 1, 1'b0);
    send_packet(8'h20, 0, 2, 1'b0);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  // largest length the field can carry; the packet is left open
  task automatic test_maximal_length_field();
    send_rx(8'h10);
    repeat (4) send_rx(8'hFF);
    repeat (6) send_rx(8'($urandom));
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_framing();
    test_random_traffic(200);
    write_capacity(24'hFFFFFF);
    sink_mode = 0;
    gaps_on   = 1'b0;
    test_random_traffic(150);
    sink_mode = 2;
    gaps_on   = 1'b1;
    test_random_traffic(150);
    test_output_backpressure();
    test_oversize_boundary();
    write_capacity(24'd2);
    sink_mode = 1;
    test_random_traffic(200);
    write_capacity(24'd0);
    sink_mode = 2;
    test_random_traffic(150);
    test_maximal_length_field();

    repeat (10) @(posedge clk_i);
    if (framed_q.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", framed_q.size());
    end
    $display("Sent %0d bytes, %0d packets closed, %0d of them with zero length",
             items_sent, packets_seen, empty_packets);
    $display("Capacities 20480, max, 6, 5, 2 and 0; oversize flag set: %b", oversize_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(RunLimit * 10);
    $display("Timeout with %0d results outstanding", framed_q.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
